>>> design/jrd_pkg.sv
`timescale 1ns / 1ps

package jrd_pkg;

    // Register map, word index = paddr[3:2]
    localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] REG_SNAP     = 2'd2;

    localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
    localparam logic [14:0] SNAP_RST     = 15'd328;
    localparam logic [14:0] FULL_SCALE   = 15'h7FFF;

    // Pipeline geometry: one root bit per cell, one quotient bit per cell
    localparam int SQRT_STEPS = 16;
    localparam int QBITS      = 16;
    localparam int PIPE_LAT   = 5 + SQRT_STEPS + QBITS;

    // Values carried beside the root
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic        neg_x;
        logic        neg_y;
        logic        zf;
    } t_side;

    // Square root cell data
    typedef struct packed {
        logic [31:0] s;
        logic [31:0] r;
        t_side       side;
    } t_sq;

    // Divider cell data
    typedef struct packed {
        logic [47:0] rem;
        logic [15:0] q;
        logic [31:0] d;
        logic        neg;
        logic        zf;
    } t_dv;

endpackage

>>> design/jrd_sqrt_cell.sv
`timescale 1ns / 1ps

module jrd_sqrt_cell
    import jrd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  t_sq  i_d,
    output t_sq  o_q
);

    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * STEP);

    t_sq         r_q;
    t_sq         n_q;
    logic [31:0] w_t;

    // One digit of the restoring square root
    always_comb begin
        w_t = i_d.r + BIT;
        n_q = i_d;
        if (i_d.s >= w_t) begin
            n_q.s = i_d.s - w_t;
            n_q.r = (i_d.r >> 1) + BIT;
        end else begin
            n_q.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> design/jrd_div_cell.sv
`timescale 1ns / 1ps

module jrd_div_cell
    import jrd_pkg::*;
#(
    parameter int QBIT = 0
) (
    input  logic i_clk,
    input  t_dv  i_d,
    output t_dv  o_q
);

    t_dv         r_q;
    t_dv         n_q;
    logic [47:0] w_dsh;

    // One quotient bit: compare against shifted divisor, subtract on fit
    always_comb begin
        w_dsh = 48'(i_d.d) << QBIT;
        n_q   = i_d;
        if (i_d.rem >= w_dsh) begin
            n_q.rem     = i_d.rem - w_dsh;
            n_q.q[QBIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> design/jrd_stick.sv
`timescale 1ns / 1ps

module jrd_stick
    import jrd_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic [14:0]        i_dz,
    input  logic [14:0]        i_snap,
    output logic signed [15:0] o_x,
    output logic signed [15:0] o_y
);

    // Stage 1: absolute values and squares
    logic [15:0] w_ax;
    logic [15:0] w_ay;
    logic [31:0] r_sqx;
    logic [31:0] r_sqy;
    logic [29:0] r_dzsq;
    t_side       r_side1;

    assign w_ax = i_x[15] ? 16'(~i_x + 16'd1) : 16'(i_x);
    assign w_ay = i_y[15] ? 16'(~i_y + 16'd1) : 16'(i_y);

    always_ff @(posedge i_clk) begin
        r_sqx         <= w_ax * w_ax;
        r_sqy         <= w_ay * w_ay;
        r_dzsq        <= i_dz * i_dz;
        r_side1.ax    <= w_ax;
        r_side1.ay    <= w_ay;
        r_side1.neg_x <= i_x[15];
        r_side1.neg_y <= i_y[15];
        r_side1.zf    <= 1'b0;
    end

    // Stage 2: magnitude squared and deadzone test
    logic [31:0] w_s;
    t_sq         r_sq0;

    assign w_s = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        r_sq0.s    <= w_s;
        r_sq0.r    <= 32'd0;
        r_sq0.side <= '{ax: r_side1.ax, ay: r_side1.ay, neg_x: r_side1.neg_x,
                        neg_y: r_side1.neg_y,
                        zf: (i_dz == FULL_SCALE) || (w_s <= {2'b00, r_dzsq})};
    end

    // Square root chain
    t_sq w_sq [SQRT_STEPS+1];

    assign w_sq[0] = r_sq0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        jrd_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_d   (w_sq[k]),
            .o_q   (w_sq[k+1])
        );
    end

    // Stage M: clamp, span products
    logic [15:0] w_m;
    logic [14:0] w_mc;
    logic [14:0] w_diff;
    t_side       w_sd;
    logic [30:0] r_px;
    logic [30:0] r_py;
    logic [30:0] r_den;
    t_side       r_side2;

    assign w_m    = w_sq[SQRT_STEPS].r[15:0];
    assign w_sd   = w_sq[SQRT_STEPS].side;
    assign w_mc   = (w_m > 16'd32767) ? FULL_SCALE : w_m[14:0];
    assign w_diff = w_sd.zf ? 15'd0 : 15'(w_mc - i_dz);

    always_ff @(posedge i_clk) begin
        r_px    <= w_sd.ax * w_diff;
        r_py    <= w_sd.ay * w_diff;
        r_den   <= w_m * 15'(FULL_SCALE - i_dz);
        r_side2 <= w_sd;
    end

    // Stage N: rounded dividend 2*num + den, divisor 2*den
    logic [45:0] w_numx;
    logic [45:0] w_numy;
    t_dv         r_dx0;
    t_dv         r_dy0;

    assign w_numx = {r_px, 15'd0} - 46'(r_px);
    assign w_numy = {r_py, 15'd0} - 46'(r_py);

    always_ff @(posedge i_clk) begin
        r_dx0.rem <= {1'b0, w_numx, 1'b0} + 48'(r_den);
        r_dx0.q   <= 16'd0;
        r_dx0.d   <= {r_den, 1'b0};
        r_dx0.neg <= r_side2.neg_x;
        r_dx0.zf  <= r_side2.zf;
        r_dy0.rem <= {1'b0, w_numy, 1'b0} + 48'(r_den);
        r_dy0.q   <= 16'd0;
        r_dy0.d   <= {r_den, 1'b0};
        r_dy0.neg <= r_side2.neg_y;
        r_dy0.zf  <= r_side2.zf;
    end

    // Divider chains, most significant quotient bit first
    t_dv w_dx [QBITS+1];
    t_dv w_dy [QBITS+1];

    assign w_dx[0] = r_dx0;
    assign w_dy[0] = r_dy0;

    for (genvar k = 0; k < QBITS; k++) begin : g_div
        jrd_div_cell #(.QBIT(QBITS - 1 - k)) u_cx (
            .i_clk (i_clk),
            .i_d   (w_dx[k]),
            .o_q   (w_dx[k+1])
        );
        jrd_div_cell #(.QBIT(QBITS - 1 - k)) u_cy (
            .i_clk (i_clk),
            .i_d   (w_dy[k]),
            .o_q   (w_dy[k+1])
        );
    end

    // Output: snap, sign
    t_dv                w_lx;
    t_dv                w_ly;
    logic signed [15:0] r_ox;
    logic signed [15:0] r_oy;

    assign w_lx = w_dx[QBITS];
    assign w_ly = w_dy[QBITS];

    always_ff @(posedge i_clk) begin
        if (w_lx.zf || (w_lx.q < {1'b0, i_snap})) begin
            r_ox <= 16'sd0;
        end else begin
            r_ox <= w_lx.neg ? signed'(16'(~w_lx.q + 16'd1)) : signed'(w_lx.q);
        end
        if (w_ly.zf || (w_ly.q < {1'b0, i_snap})) begin
            r_oy <= 16'sd0;
        end else begin
            r_oy <= w_ly.neg ? signed'(16'(~w_ly.q + 16'd1)) : signed'(w_ly.q);
        end
    end

    assign o_x = r_ox;
    assign o_y = r_oy;

`ifndef ASSERT_OFF
    a_zero_in_deadzone: assert property (@(posedge i_clk)
        w_lx.zf |=> (o_x == 16'sd0 && o_y == 16'sd0))
        else $error("stick inside deadzone gave nonzero output");
`endif

endmodule

>>> design/joystick_radial_deadzone.sv
`timescale 1ns / 1ps

// Radial deadzone scaler for a two-stick controller sample. A sample is taken
// on any cycle with start high; busy never rises, so one sample per clock is
// sustained. Each result appears on the o_ ports for one cycle with o_strobe
// after the squaring and deadzone stages, 16 square-root cells (one root bit
// each), product and dividend stages, 16 divider cells (one quotient bit
// each) and an output register. Results cannot be held off by the receiver.
// The user must write deadzone and snap registers through the APB port only
// while no sample is in flight; the block itself does not enforce this.
module joystick_radial_deadzone
    import jrd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [7:0]         i_left_trigger_raw,
    input  logic [7:0]         i_right_trigger_raw,
    input  logic [15:0]        i_button_bits,
    output logic               o_strobe,
    output logic signed [15:0] o_left_x_scaled,
    output logic signed [15:0] o_left_y_scaled,
    output logic signed [15:0] o_right_x_scaled,
    output logic signed [15:0] o_right_y_scaled,
    output logic [15:0]        o_left_trigger_level,
    output logic [15:0]        o_right_trigger_level,
    output logic [15:0]        o_buttons_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [14:0] r_left_dz;
    logic [14:0] r_right_dz;
    logic [14:0] r_snap;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= LEFT_DZ_RST;
            r_right_dz <= RIGHT_DZ_RST;
            r_snap     <= SNAP_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_LEFT_DZ:  r_left_dz  <= pwdata[14:0];
                REG_RIGHT_DZ: r_right_dz <= pwdata[14:0];
                REG_SNAP:     r_snap     <= pwdata[14:0];
                default:      ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[3:2])
            REG_LEFT_DZ:  prdata = {17'd0, r_left_dz};
            REG_RIGHT_DZ: prdata = {17'd0, r_right_dz};
            REG_SNAP:     prdata = {17'd0, r_snap};
            default:      prdata = 32'd0;
        endcase
    end

    // Fully pipelined: a new beat every cycle
    logic w_acc;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    // Stick pipelines
    jrd_stick u_left (
        .i_clk  (i_clk),
        .i_x    (i_left_x),
        .i_y    (i_left_y),
        .i_dz   (r_left_dz),
        .i_snap (r_snap),
        .o_x    (o_left_x_scaled),
        .o_y    (o_left_y_scaled)
    );

    jrd_stick u_right (
        .i_clk  (i_clk),
        .i_x    (i_right_x),
        .i_y    (i_right_y),
        .i_dz   (r_right_dz),
        .i_snap (r_snap),
        .o_x    (o_right_x_scaled),
        .o_y    (o_right_y_scaled)
    );

    // Valid tag and side payload delay line, matched to the stick latency
    logic [PIPE_LAT-1:0] r_vld;
    logic [15:0]         r_ltrig [PIPE_LAT];
    logic [15:0]         r_rtrig [PIPE_LAT];
    logic [15:0]         r_btn   [PIPE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        // raw * 257 is the byte repeated
        r_ltrig[0] <= {i_left_trigger_raw, i_left_trigger_raw};
        r_rtrig[0] <= {i_right_trigger_raw, i_right_trigger_raw};
        r_btn[0]   <= i_button_bits;
        for (int i = 1; i < PIPE_LAT; i++) begin
            r_ltrig[i] <= r_ltrig[i-1];
            r_rtrig[i] <= r_rtrig[i-1];
            r_btn[i]   <= r_btn[i-1];
        end
    end

    assign o_strobe              = r_vld[PIPE_LAT-1];
    assign o_left_trigger_level  = r_ltrig[PIPE_LAT-1];
    assign o_right_trigger_level = r_rtrig[PIPE_LAT-1];
    assign o_buttons_out         = r_btn[PIPE_LAT-1];

`ifndef ASSERT_OFF
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, PIPE_LAT))
        else $error("result beat without matching start");
    a_trigger_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_left_trigger_level[15:8] == o_left_trigger_level[7:0] &&
                      o_right_trigger_level[15:8] == o_right_trigger_level[7:0]))
        else $error("trigger level is not raw times 257");
`endif

endmodule

>>> tb/joystick_radial_deadzone_tb.sv
`timescale 1ns / 1ps

module joystick_radial_deadzone_tb;
    import jrd_pkg::*;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [7:0]         ltrig;
        logic [7:0]         rtrig;
        logic [15:0]        btn;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [15:0]        ltrig;
        logic [15:0]        rtrig;
        logic [15:0]        btn;
    } t_scaled;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = PIPE_LAT + 10;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_left_x = '0;
    logic signed [15:0] i_left_y = '0;
    logic signed [15:0] i_right_x = '0;
    logic signed [15:0] i_right_y = '0;
    logic [7:0]         i_left_trigger_raw = '0;
    logic [7:0]         i_right_trigger_raw = '0;
    logic [15:0]        i_button_bits = '0;
    logic               o_strobe;
    logic signed [15:0] o_left_x_scaled;
    logic signed [15:0] o_left_y_scaled;
    logic signed [15:0] o_right_x_scaled;
    logic signed [15:0] o_right_y_scaled;
    logic [15:0]        o_left_trigger_level;
    logic [15:0]        o_right_trigger_level;
    logic [15:0]        o_buttons_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    always #1 i_clk = ~i_clk;

    joystick_radial_deadzone u_top (.*);

    // Mirror of the deadzone registers
    logic [14:0] left_dz_m = LEFT_DZ_RST;
    logic [14:0] right_dz_m = RIGHT_DZ_RST;
    logic [14:0] snap_m = SNAP_RST;

    t_sample sample_q[$];
    t_scaled scaled_q[$];
    int      cycle_cnt = 0;
    int      fail_cnt = 0;
    bit      quiet_tail = 0;
    bit      hold_driver = 0;

    // Integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= s) r += (64'd1 << b);
        end
        return r;
    endfunction

    // One stick: deadzone removal, rescale along direction, axis snap
    function automatic void stick_scale(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic [14:0] dz,
                                        output logic signed [15:0] ox,
                                        output logic signed [15:0] oy);
        longint unsigned ax, ay, s, m, mc, den, num, q;
        ax = (x < 0) ? -longint'(x) : x;
        ay = (y < 0) ? -longint'(y) : y;
        s = ax * ax + ay * ay;
        ox = 0;
        oy = 0;
        if (dz != FULL_SCALE && s > longint'(dz) * dz) begin
            m = root_floor(s);
            mc = (m > 32767) ? 32767 : m;
            den = m * (32767 - dz);
            num = ax * (mc - dz) * 32767;
            q = (2 * num + den) / (2 * den);
            if (q < snap_m) q = 0;
            ox = (x < 0) ? -q[15:0] : q[15:0];
            num = ay * (mc - dz) * 32767;
            q = (2 * num + den) / (2 * den);
            if (q < snap_m) q = 0;
            oy = (y < 0) ? -q[15:0] : q[15:0];
        end
    endfunction

    function automatic t_scaled scale_sample(t_sample smp);
        t_scaled res;
        logic signed [15:0] a, b;
        stick_scale(smp.lx, smp.ly, left_dz_m, a, b);
        res.lx = a;
        res.ly = b;
        stick_scale(smp.rx, smp.ry, right_dz_m, a, b);
        res.rx = a;
        res.ry = b;
        res.ltrig = smp.ltrig * 16'd257;
        res.rtrig = smp.rtrig * 16'd257;
        res.btn = smp.btn;
        return res;
    endfunction

    // Driver: one sample per accepted beat, random idle bursts
    int idle_left = 0;
    always @(posedge i_clk) begin
        t_sample nxt;
        if (start && !busy) begin
            scaled_q.push_back(scale_sample(sample_q.pop_front()));
        end
        if (!i_rst_n || hold_driver) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            idle_left <= $urandom_range(0, 4);
            start <= 1'b0;
        end else if (sample_q.size() > 0) begin
            // head of queue is the next beat; peek without popping
            nxt = sample_q[0];
            start <= 1'b1;
            i_left_x <= nxt.lx;
            i_left_y <= nxt.ly;
            i_right_x <= nxt.rx;
            i_right_y <= nxt.ry;
            i_left_trigger_raw <= nxt.ltrig;
            i_right_trigger_raw <= nxt.rtrig;
            i_button_bits <= nxt.btn;
        end else begin
            start <= 1'b0;
        end
    end

    // Pop happens at acceptance, so the driven beat must stay at queue head
    // until then: a new beat is only loaded when start is low or accepted.

    // Monitor
    always @(posedge i_clk) begin
        t_scaled e;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n && o_strobe) begin
            if (scaled_q.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt = fail_cnt + 1;
            end else begin
                e = scaled_q.pop_front();
                if (o_left_x_scaled !== e.lx) begin
                    $error("left_x_scaled exp %0d got %0d", e.lx, o_left_x_scaled);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_left_y_scaled !== e.ly) begin
                    $error("left_y_scaled exp %0d got %0d", e.ly, o_left_y_scaled);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_right_x_scaled !== e.rx) begin
                    $error("right_x_scaled exp %0d got %0d", e.rx, o_right_x_scaled);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_right_y_scaled !== e.ry) begin
                    $error("right_y_scaled exp %0d got %0d", e.ry, o_right_y_scaled);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_left_trigger_level !== e.ltrig) begin
                    $error("left_trigger_level exp %0d got %0d", e.ltrig,
                           o_left_trigger_level);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_right_trigger_level !== e.rtrig) begin
                    $error("right_trigger_level exp %0d got %0d", e.rtrig,
                           o_right_trigger_level);
                    fail_cnt = fail_cnt + 1;
                end
                if (o_buttons_out !== e.btn) begin
                    $error("buttons_out exp %0h got %0h", e.btn, o_buttons_out);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // APB write: setup then access beat
    task automatic reg_write(input logic [1:0] idx, input logic [14:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {17'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LEFT_DZ:  left_dz_m = val;
            REG_RIGHT_DZ: right_dz_m = val;
            default:      snap_m = val;
        endcase
    endtask

    // Wait until the pipe is empty, then let trailing beats settle
    task automatic drain();
        while (sample_q.size() > 0 || scaled_q.size() > 0 || start) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return $signed(16'($urandom_range(0, 600))) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic signed [15:0] lx, ly, rx, ry,
                               input logic [7:0] lt, rt, input logic [15:0] b);
        sample_q.push_back('{lx, ly, rx, ry, lt, rt, b});
    endtask

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            push_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                        8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero magnitude, corners, deadzone edge, triggers, buttons
        push_sample(0, 0, 0, 0, 8'd0, 8'd255, 16'h0000);
        push_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 8'd255, 8'd0, 16'hFFFF);
        push_sample(16'sh8000, 0, 0, 16'sh8000, 8'd1, 8'd128, 16'hA5A5);
        push_sample(7849, 0, 8689, 0, 8'd2, 8'd3, 16'h5A5A);
        push_sample(7850, 0, 0, -8690, 8'd4, 8'd5, 16'h0001);
        push_sample(-7850, 1, 100, 8700, 8'd6, 8'd7, 16'h8000);
        push_sample(30000, 200, -200, 30000, 8'd8, 8'd9, 16'h1234);
        push_sample(16'sh7FFF, 0, 0, 16'sh7FFF, 8'd10, 8'd11, 16'h4321);
        drain();

        // Left deadzone zero, right deadzone near full scale, no snapping
        reg_write(REG_LEFT_DZ, 15'd0);
        reg_write(REG_RIGHT_DZ, 15'd32766);
        reg_write(REG_SNAP, 15'd0);
        push_sample(1, 0, 32767, 0, 8'd0, 8'd0, 16'd0);
        push_sample(-1, -1, 16'sh8000, 16'sh8000, 8'd0, 8'd0, 16'd0);
        push_sample(0, 0, 0, 0, 8'd0, 8'd0, 16'd0);
        random_phase(300);
        drain();

        // Full-scale left deadzone, zero right deadzone and maximum snap
        reg_write(REG_LEFT_DZ, 15'd32767);
        reg_write(REG_RIGHT_DZ, 15'd0);
        reg_write(REG_SNAP, 15'd32767);
        push_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 8'd0, 8'd0, 16'd0);
        push_sample(16'sh8000, 0, 16'sh8000, 0, 8'd0, 8'd0, 16'd0);
        random_phase(300);
        drain();

        // Mid settings
        reg_write(REG_LEFT_DZ, 15'($urandom_range(1000, 20000)));
        reg_write(REG_RIGHT_DZ, 15'($urandom_range(1000, 20000)));
        reg_write(REG_SNAP, 15'($urandom_range(1, 3000)));
        random_phase(600);
        drain();

        // Reset values again, final stretch ends with no idling
        reg_write(REG_LEFT_DZ, LEFT_DZ_RST);
        reg_write(REG_RIGHT_DZ, RIGHT_DZ_RST);
        reg_write(REG_SNAP, SNAP_RST);
        random_phase(637);
        while (sample_q.size() > 200) @(posedge i_clk);
        quiet_tail = 1;
        drain();

        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
